### rtl/lsbx_pkg.sv
// shared types and constants for the lsb stego payload extractor
package lsbx_pkg;

	localparam int KEY_BYTES = 8;
	localparam int KEY_POS_W = (KEY_BYTES > 1) ? $clog2(KEY_BYTES) : 1;
	localparam int KEY_LEN_W = 4;
	localparam int CFG_IDX_W = 2;
	localparam int CFG_DATA_W = 64;
	localparam int HDR_IDX_W = 4;

	localparam logic [HDR_IDX_W-1:0] HDR_LAST_IDX = HDR_IDX_W'(8);
	localparam logic [HDR_IDX_W-1:0] HDR_CIPHER_IDX = HDR_IDX_W'(4);

	localparam logic [31:0] FNV_BASIS = 32'h811C_9DC5;
	localparam logic [31:0] FNV_PRIME = 32'd16777619;
	localparam logic [63:0] FNV_SEED_WIDE = 64'(FNV_BASIS) * 64'(FNV_PRIME);
	// basis already multiplied by the prime, ready for the first message byte
	localparam logic [31:0] FNV_SEED_PROD = FNV_SEED_WIDE[31:0];

	// configuration register indexes
	localparam logic [CFG_IDX_W-1:0] CFG_CAESAR_SHIFT = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_KEY_BYTES = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_KEY_LENGTH = 2'd2;

	// cipher ids
	localparam logic [7:0] CID_PLAIN = 8'd0;
	localparam logic [7:0] CID_SHIFT = 8'd1;
	localparam logic [7:0] CID_KEYED = 8'd2;

	// result status codes
	localparam logic [1:0] ST_OK = 2'd0;
	localparam logic [1:0] ST_SUM_BAD = 2'd1;
	localparam logic [1:0] ST_BAD_CIPHER = 2'd2;
	localparam logic [1:0] ST_TRUNCATED = 2'd3;

	typedef enum logic [2:0] {
		PH_HEADER = 3'b001,
		PH_MESSAGE = 3'b010,
		PH_SKIP = 3'b100
	} phase_t;

	typedef struct packed {
		logic [7:0] pixel_byte;
		logic end_of_image;
	} in_item_t;

	typedef struct packed {
		logic [7:0] plain_byte;
		logic byte_valid;
		logic is_last;
		logic [1:0] status;
	} out_item_t;

endpackage

### rtl/lsb_stego_payload_extractor_core.sv
// lsb stego payload extractor: header parse, fnv-1 check, decrypt, one result per byte
// an item sits in the input register, its result (if any) then in the result register
// throughput: one image byte per cycle while no result stalls; the input register and
//   the result register advance together; a stall holds both and sets in_stall
// reset: arst_n clears the control state, the configuration registers go to
//   caesar_shift 0, key 0, key_length 1; the extractor starts in the header phase
module lsb_stego_payload_extractor_core (
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	output logic in_stall,
	input  lsbx_pkg::in_item_t in_item,
	output logic out_valid,
	input  logic out_stall,
	output lsbx_pkg::out_item_t out_item,
	input  logic cfg_we,
	input  logic [lsbx_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [lsbx_pkg::CFG_DATA_W-1:0] cfg_wdata
);
	import lsbx_pkg::*;

	// configuration registers
	logic [7:0] caesar_shift_q;
	logic [CFG_DATA_W-1:0] key_bytes_q;
	logic [KEY_LEN_W-1:0] key_length_q;

	// input register
	logic valid_s1;
	in_item_t item_s1;

	// extractor state
	phase_t phase_q, phase_n;
	logic [2:0] bit_pos_q, bit_pos_n;
	logic [7:0] gather_q, gather_n;
	logic [HDR_IDX_W-1:0] hdr_idx_q, hdr_idx_n;
	logic [31:0] length_q, length_n;
	logic [7:0] cipher_q, cipher_n;
	logic [31:0] stored_q, stored_n;
	// running checksum already multiplied by the prime, so a message byte only xors
	logic [31:0] mulsum_q, mulsum_n;
	logic [31:0] bytes_left_q, bytes_left_n;
	logic [KEY_POS_W-1:0] key_pos_q, key_pos_n;

	// result register
	logic out_valid_q;
	out_item_t out_item_q;

	// per-item datapath
	logic advance;
	logic emit;
	out_item_t result;
	logic [7:0] gathered;
	logic byte_done;
	logic eoi;
	logic [31:0] stored_full;
	logic [31:0] new_sum;
	logic [31:0] sum_prod;
	logic [7:0] key_byte;
	logic [7:0] plain;
	logic [KEY_LEN_W-1:0] key_len_act;
	logic [KEY_LEN_W-1:0] key_pos_inc;
	logic [1:0] stored_sel;

	// the input register moves whenever the result register can take a new value
	assign advance = valid_s1 && !(out_valid_q && out_stall);
	assign in_stall = valid_s1 && !advance;

	assign out_valid = out_valid_q;
	assign out_item = out_item_q;

	// configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			caesar_shift_q <= '0;
			key_bytes_q <= '0;
			key_length_q <= KEY_LEN_W'(1);
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_CAESAR_SHIFT: caesar_shift_q <= cfg_wdata[7:0];
				CFG_KEY_BYTES: key_bytes_q <= cfg_wdata;
				CFG_KEY_LENGTH: key_length_q <= cfg_wdata[KEY_LEN_W-1:0];
				default: ;
			endcase
		end
	end

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!in_stall) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (!in_stall) begin
			item_s1 <= in_item;
		end
	end

	// payload bit collection, lsb first
	assign eoi = item_s1.end_of_image;
	assign gathered = gather_q | (8'(item_s1.pixel_byte[0]) << bit_pos_q);
	assign byte_done = (bit_pos_q == 3'd7);

	// checksum bytes sit at header places five to eight
	assign stored_sel = 2'(hdr_idx_q - HDR_IDX_W'(5));
	assign stored_full = {gathered, stored_q[23:0]};

	// fnv-1 fold and pre-multiply for the following byte, low 32 bits only
	assign new_sum = mulsum_q ^ {24'd0, gathered};
	assign sum_prod = new_sum * FNV_PRIME;

	// vigenere key selection; a key length of zero acts as one, too large as the maximum
	always_comb begin
		if (key_length_q == '0) begin
			key_len_act = KEY_LEN_W'(1);
		end else if (key_length_q > KEY_LEN_W'(KEY_BYTES)) begin
			key_len_act = KEY_LEN_W'(KEY_BYTES);
		end else begin
			key_len_act = key_length_q;
		end
	end

	assign key_pos_inc = KEY_LEN_W'(key_pos_q) + KEY_LEN_W'(1);
	assign key_byte = key_bytes_q[{key_pos_q, 3'b000} +: 8];

	always_comb begin
		case (cipher_q)
			CID_SHIFT: plain = gathered - caesar_shift_q;
			CID_KEYED: plain = gathered - key_byte;
			default: plain = gathered;
		endcase
	end

	// next state and result for the item in the input register
	always_comb begin
		phase_n = phase_q;
		bit_pos_n = bit_pos_q;
		gather_n = gather_q;
		hdr_idx_n = hdr_idx_q;
		length_n = length_q;
		cipher_n = cipher_q;
		stored_n = stored_q;
		mulsum_n = mulsum_q;
		bytes_left_n = bytes_left_q;
		key_pos_n = key_pos_q;
		emit = 1'b0;
		result = '0;

		unique case (phase_q)
			PH_SKIP: begin
				// nothing until the image ends
				if (eoi) begin
					phase_n = PH_HEADER;
				end
			end
			PH_HEADER, PH_MESSAGE: begin
				if (!byte_done) begin
					bit_pos_n = bit_pos_q + 3'd1;
					gather_n = gathered;
					if (eoi) begin
						emit = 1'b1;
						result.is_last = 1'b1;
						result.status = ST_TRUNCATED;
						phase_n = PH_HEADER;
					end
				end else begin
					bit_pos_n = '0;
					gather_n = '0;
					if (phase_q == PH_HEADER) begin
						case (hdr_idx_q) inside
							[4'd0:4'd3]: length_n[{hdr_idx_q[1:0], 3'b000} +: 8] = gathered;
							HDR_CIPHER_IDX: cipher_n = gathered;
							default: stored_n[{stored_sel, 3'b000} +: 8] = gathered;
						endcase
						if (hdr_idx_q != HDR_LAST_IDX) begin
							hdr_idx_n = hdr_idx_q + HDR_IDX_W'(1);
							if (eoi) begin
								emit = 1'b1;
								result.is_last = 1'b1;
								result.status = ST_TRUNCATED;
								phase_n = PH_HEADER;
							end
						end else if (cipher_q > CID_KEYED) begin
							emit = 1'b1;
							result.is_last = 1'b1;
							result.status = ST_BAD_CIPHER;
							phase_n = eoi ? PH_HEADER : PH_SKIP;
						end else if (length_q == '0) begin
							// empty message: check against the bare basis
							emit = 1'b1;
							result.is_last = 1'b1;
							result.status = (stored_full != FNV_BASIS) ? ST_SUM_BAD : ST_OK;
							phase_n = eoi ? PH_HEADER : PH_SKIP;
						end else begin
							bytes_left_n = length_q;
							phase_n = PH_MESSAGE;
							if (eoi) begin
								emit = 1'b1;
								result.is_last = 1'b1;
								result.status = ST_TRUNCATED;
								phase_n = PH_HEADER;
							end
						end
					end else begin
						mulsum_n = sum_prod;
						bytes_left_n = bytes_left_q - 32'd1;
						if (cipher_q == CID_KEYED) begin
							key_pos_n = (key_pos_inc >= key_len_act) ? '0 :
								KEY_POS_W'(key_pos_inc);
						end
						emit = 1'b1;
						result.plain_byte = plain;
						result.byte_valid = 1'b1;
						if (bytes_left_q == 32'd1) begin
							result.is_last = 1'b1;
							result.status = (new_sum != stored_q) ? ST_SUM_BAD : ST_OK;
							phase_n = eoi ? PH_HEADER : PH_SKIP;
						end else if (eoi) begin
							result.is_last = 1'b1;
							result.status = ST_TRUNCATED;
							phase_n = PH_HEADER;
						end
					end
				end
			end
			default: phase_n = PH_HEADER;
		endcase

		// end of image always restarts the extractor for the next one
		if (eoi) begin
			phase_n = PH_HEADER;
			bit_pos_n = '0;
			gather_n = '0;
			hdr_idx_n = '0;
			mulsum_n = FNV_SEED_PROD;
			bytes_left_n = '0;
			key_pos_n = '0;
		end
	end

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_HEADER;
			bit_pos_q <= '0;
			gather_q <= '0;
			hdr_idx_q <= '0;
			mulsum_q <= FNV_SEED_PROD;
			bytes_left_q <= '0;
			key_pos_q <= '0;
			cipher_q <= '0;
		end else if (advance) begin
			phase_q <= phase_n;
			bit_pos_q <= bit_pos_n;
			gather_q <= gather_n;
			hdr_idx_q <= hdr_idx_n;
			mulsum_q <= mulsum_n;
			bytes_left_q <= bytes_left_n;
			key_pos_q <= key_pos_n;
			cipher_q <= cipher_n;
		end
	end

	// header fields, always fully written before use
	always_ff @(posedge clk) begin
		if (advance) begin
			length_q <= length_n;
			stored_q <= stored_n;
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= emit;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			out_item_q <= result;
		end
	end

	// a result without a message byte is always the final one
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (out_item.byte_valid || out_item.is_last))
		else $error("result without byte and without is_last");

	// status is only reported on the final result
	assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !out_item.is_last) |-> (out_item.status == ST_OK))
		else $error("status on a non-final result");

	// skip phase is only entered on a byte boundary
	assert property (@(posedge clk) disable iff (!arst_n)
		(phase_q == PH_SKIP) |-> (bit_pos_q == 3'd0 && gather_q == 8'd0))
		else $error("skip phase with partial byte");

	// message phase always has bytes to go
	assert property (@(posedge clk) disable iff (!arst_n)
		(phase_q == PH_MESSAGE) |-> (bytes_left_q != 32'd0))
		else $error("message phase with no bytes left");

endmodule
